FILE: rtl/ucfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfs_pkg: shared types and constants of the UART command frame sniffer
// Result kinds, register indexes, frame phases, the register set and the
// result batch handed from the frame engine to the output stage.
// ----------------------------------------------------------------------------
package ucfs_pkg;

	localparam int BATCH_MAX = 5;

	typedef enum logic [1:0] {
		KIND_PASS   = 2'd0,
		KIND_START  = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_EOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_HEADER_ONE   = 3'd0,
		REG_HEADER_TWO   = 3'd1,
		REG_HEADER_THREE = 3'd2,
		REG_START_PREFIX = 3'd3,
		REG_START_SUFFIX = 3'd4,
		REG_CANCEL_PREFIX = 3'd5,
		REG_CANCEL_SUFFIX = 3'd6,
		REG_GAP_RELOAD   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_HDR2   = 3'd2,
		PH_HDR3   = 3'd3,
		PH_PREFIX = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] header_one;
		logic [7:0] header_two;
		logic [7:0] header_three;
		logic [7:0] start_prefix;
		logic [7:0] start_suffix;
		logic [7:0] cancel_prefix;
		logic [7:0] cancel_suffix;
		logic [7:0] gap_reload;
	} cfg_t;

	// Results caused by one item: count, common kind, bytes in emit order
	typedef struct packed {
		logic [2:0]                 n;
		kind_t                      kind;
		logic [BATCH_MAX-1:0][7:0]  bytes;
	} batch_t;

endpackage

FILE: rtl/ucfs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfs_core: frame matcher and gap timer
// Holds the frame phase, held frame bytes, gap counter and pending flag,
// and works out the result batch for the item presented at its input.
// ----------------------------------------------------------------------------
module ucfs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                mode,
	input  logic [7:0]          rx_byte,
	input  ucfs_pkg::cfg_t      cfg,
	output ucfs_pkg::batch_t    batch
);

	ucfs_pkg::phase_t phase_q, phase_d;
	logic [3:0][7:0]  held_q;
	logic             held_we;
	logic [1:0]       held_idx;
	logic [7:0]       gap_q, gap_d;
	logic             pend_q, pend_d;
	logic [2:0]       cnt;

	// Next state, result count and result bytes
	always_comb begin
		phase_d    = phase_q;
		gap_d      = gap_q;
		pend_d     = pend_q;
		held_we    = 1'b0;
		held_idx   = 2'd0;
		batch.n    = 3'd0;
		batch.kind = ucfs_pkg::KIND_PASS;
		case (phase_q)
			ucfs_pkg::PH_HDR1:   cnt = 3'd1;
			ucfs_pkg::PH_HDR2:   cnt = 3'd2;
			ucfs_pkg::PH_HDR3:   cnt = 3'd3;
			ucfs_pkg::PH_PREFIX: cnt = 3'd4;
			default:             cnt = 3'd0;
		endcase
		// Held bytes come out first, the current byte right after them
		for (int i = 0; i < ucfs_pkg::BATCH_MAX; i++) begin
			if (i < 4 && 3'(i) < cnt) begin
				batch.bytes[i] = held_q[i[1:0]];
			end else begin
				batch.bytes[i] = rx_byte;
			end
		end
		if (mode) begin
			// Tick: count down, close the burst at one
			if (gap_q > 8'd1) begin
				gap_d = gap_q - 8'd1;
			end
			if (gap_d == 8'd1) begin
				gap_d = 8'd0;
				if (pend_q) begin
					batch.n    = 3'd1;
					batch.kind = ucfs_pkg::KIND_EOP;
					pend_d     = 1'b0;
				end
			end
		end else begin
			gap_d = cfg.gap_reload;
			case (phase_q)
				ucfs_pkg::PH_HDR1: begin
					if (rx_byte == cfg.header_two) begin
						held_we  = 1'b1;
						held_idx = 2'd1;
						phase_d  = ucfs_pkg::PH_HDR2;
					end else begin
						batch.n = cnt + 3'd1;
						pend_d  = 1'b1;
						phase_d = ucfs_pkg::PH_IDLE;
					end
				end
				ucfs_pkg::PH_HDR2: begin
					if (rx_byte == cfg.header_three) begin
						held_we  = 1'b1;
						held_idx = 2'd2;
						phase_d  = ucfs_pkg::PH_HDR3;
					end else begin
						batch.n = cnt + 3'd1;
						pend_d  = 1'b1;
						phase_d = ucfs_pkg::PH_IDLE;
					end
				end
				ucfs_pkg::PH_HDR3: begin
					if (rx_byte == cfg.start_prefix ||
						rx_byte == cfg.cancel_prefix) begin
						held_we  = 1'b1;
						held_idx = 2'd3;
						phase_d  = ucfs_pkg::PH_PREFIX;
					end else begin
						batch.n = cnt + 3'd1;
						pend_d  = 1'b1;
						phase_d = ucfs_pkg::PH_IDLE;
					end
				end
				ucfs_pkg::PH_PREFIX: begin
					phase_d = ucfs_pkg::PH_IDLE;
					if (held_q[3] == cfg.start_prefix && rx_byte == cfg.start_suffix) begin
						batch.n    = 3'd1;
						batch.kind = ucfs_pkg::KIND_START;
					end else if (held_q[3] == cfg.cancel_prefix &&
						rx_byte == cfg.cancel_suffix) begin
						batch.n    = 3'd1;
						batch.kind = ucfs_pkg::KIND_CANCEL;
					end else begin
						batch.n = cnt + 3'd1;
						pend_d  = 1'b1;
					end
				end
				default: begin
					if (rx_byte == cfg.header_one) begin
						held_we  = 1'b1;
						held_idx = 2'd0;
						phase_d  = ucfs_pkg::PH_HDR1;
					end else begin
						batch.n = 3'd1;
						pend_d  = 1'b1;
						phase_d = ucfs_pkg::PH_IDLE;
					end
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ucfs_pkg::PH_IDLE;
			gap_q   <= 8'd0;
			pend_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			gap_q   <= gap_d;
			pend_q  <= pend_d;
		end
	end

	// Held frame bytes
	always_ff @(posedge clk) begin
		if (step && held_we) begin
			held_q[held_idx] <= rx_byte;
		end
	end

endmodule

FILE: rtl/uart_command_frame_sniffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_frame_sniffer: top level
// Finds start/cancel pairing command frames in a UART byte stream, passes
// other bytes through and marks the end of each byte burst.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat is a received byte (mode 0)
//   or a millisecond tick (mode 1). Output channel (out_valid/out_ready):
//   one beat is a result with kind, out_byte and last; last marks the final
//   result of an input beat. Registers are written through cfg_we,
//   cfg_index and cfg_data; the user must do so only while the block is
//   idle, since the block itself does not enforce this. An accepted beat
//   is registered in the input register and evaluated there once its
//   results have room; they are then loaded into the batch register.
//   Throughput: one input beat per cycle while each beat gives at most one
//   result and the output is taken. A beat giving n results holds the
//   output batch register until they are popped one by one; a broken
//   frame gives up to five. Beats giving no result pass without waiting.
//   A stalled receiver holds the batch register; the input register then
//   holds one more beat before in_ready drops.
//   Reset clears the frame phase, gap counter, pending flag and valid
//   flags and loads the register reset values.
// ----------------------------------------------------------------------------
module uart_command_frame_sniffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       last,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	ucfs_pkg::cfg_t   cfg_q;
	logic             valid_s1;
	logic             mode_s1;
	logic [7:0]       byte_s1;
	ucfs_pkg::batch_t batch;
	logic [2:0]       rem_q;
	ucfs_pkg::kind_t  kind_q;
	logic [ucfs_pkg::BATCH_MAX-1:0][7:0] bytes_q;
	logic             pop;
	logic             batch_free;
	logic             step;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_one    <= 8'd128;
			cfg_q.header_two    <= 8'd3;
			cfg_q.header_three  <= 8'd2;
			cfg_q.start_prefix  <= 8'd0;
			cfg_q.start_suffix  <= 8'd0;
			cfg_q.cancel_prefix <= 8'd0;
			cfg_q.cancel_suffix <= 8'd0;
			cfg_q.gap_reload    <= 8'd6;
		end else if (cfg_we) begin
			case (ucfs_pkg::reg_idx_t'(cfg_index))
				ucfs_pkg::REG_HEADER_ONE:    cfg_q.header_one    <= cfg_data;
				ucfs_pkg::REG_HEADER_TWO:    cfg_q.header_two    <= cfg_data;
				ucfs_pkg::REG_HEADER_THREE:  cfg_q.header_three  <= cfg_data;
				ucfs_pkg::REG_START_PREFIX:  cfg_q.start_prefix  <= cfg_data;
				ucfs_pkg::REG_START_SUFFIX:  cfg_q.start_suffix  <= cfg_data;
				ucfs_pkg::REG_CANCEL_PREFIX: cfg_q.cancel_prefix <= cfg_data;
				ucfs_pkg::REG_CANCEL_SUFFIX: cfg_q.cancel_suffix <= cfg_data;
				ucfs_pkg::REG_GAP_RELOAD:    cfg_q.gap_reload    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: evaluate the held beat once its results have room
	assign pop        = out_valid && out_ready;
	assign batch_free = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready);
	assign step       = valid_s1 && (batch.n == 3'd0 || batch_free);
	assign in_ready   = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
	end

	ucfs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.mode    (mode_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.batch   (batch)
	);

	// Batch register: load a new batch, else drain one beat per pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (step && batch.n != 3'd0) begin
			rem_q <= batch.n;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && batch.n != 3'd0) begin
			kind_q  <= batch.kind;
			bytes_q <= batch.bytes;
		end else if (pop) begin
			bytes_q <= {8'd0, bytes_q[ucfs_pkg::BATCH_MAX-1:1]};
		end
	end

	// Output drive
	assign out_valid = (rem_q != 3'd0);
	assign kind      = kind_q;
	assign out_byte  = (kind_q == ucfs_pkg::KIND_PASS) ? bytes_q[0] : 8'd0;
	assign last      = (rem_q == 3'd1);

endmodule
